// ----- sv/cvd_pkg.sv -----
package cvd_pkg;

    // Field widths
    localparam int TIME_WIDTH = 34;
    localparam int ACC_WIDTH  = 48;
    localparam int PRICE_W    = 32;
    localparam int VOL_W      = 32;
    localparam int OUT_W      = 48;

    // Day number: bar_time / 86400 = (bar_time >> 7) / 675.
    // The odd part is a multiply by a rounded-up reciprocal; the rounding
    // error stays below 675 / 2^10 of one unit over the whole range, so the
    // quotient is exact for any TIME_WIDTH.
    localparam int SECS_PER_DAY = 86400;
    localparam int DAY_SHIFT    = 7;
    localparam int DIV_ODD      = SECS_PER_DAY >> DAY_SHIFT;
    localparam int XW           = TIME_WIDTH - DAY_SHIFT;
    localparam int RECIP_SHIFT  = XW + 10;
    localparam int RECIP_W      = XW + 1;
    localparam int PROD_W       = XW + RECIP_W;
    localparam int DAY_W        = TIME_WIDTH - 16;
    localparam logic [63:0] RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(DIV_ODD - 1)) / 64'(DIV_ODD);

    localparam int ACC_X = ACC_WIDTH + 1;
    localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [TIME_WIDTH-1:0] bar_time;
        logic [PRICE_W-1:0]    open_price;
        logic [PRICE_W-1:0]    close_price;
        logic [VOL_W-1:0]      volume;
        logic                  has_trade;
        logic                  bar_end;
    } cvd_in_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] bar_open;
        logic signed [OUT_W-1:0] bar_high;
        logic signed [OUT_W-1:0] bar_low;
        logic signed [OUT_W-1:0] bar_close;
    } cvd_out_t;

    typedef enum logic [1:0] {
        DIR_NONE,
        DIR_UP,
        DIR_DOWN
    } dir_t;

    // Clamp a one-bit-wider sum back into the accumulator range.
    function automatic logic signed [ACC_WIDTH-1:0] sat_acc(
        input logic signed [ACC_WIDTH:0] s
    );
        logic signed [ACC_WIDTH-1:0] r;
        if (s[ACC_WIDTH] != s[ACC_WIDTH-1])
        begin
            r = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
        end
        else
        begin
            r = s[ACC_WIDTH-1:0];
        end
        return r;
    endfunction

    // Sign-extend or truncate an accumulator value to the output width.
    function automatic logic [OUT_W-1:0] to_out(
        input logic signed [ACC_WIDTH-1:0] v
    );
        logic signed [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

endpackage

// ----- sv/cumulative_volume_delta_bars.sv -----
// Cumulative volume delta candles, one per chart bar.
//
// Input channel (in_valid / in_ready / in_data): one trade sub-bar per
// transaction, tagged with its chart bar start time; bar_end marks the last
// item of a bar, has_trade = 0 marks an item with no trade (empty bar).
// Output channel (out_valid / out_ready / out_data): one candle (open, high,
// low, close of the cumulative delta) per item that carries bar_end.
//
// Pipeline: input register, day-number multiply and price compare, bar
// delta update with high/low tracking, candle sums into the output register.
// The block takes one transaction every cycle while no stalled candle holds
// the stages full; the per-stage adds and the single reciprocal multiply set
// the clock, not the rate.
//
// Reset clears all bar state and the carried total to zero; the first bar
// after reset never clears the carried total on a day change.
// When the receiver stalls, the output register holds its candle; items
// without bar_end keep flowing, and in_ready drops only once every stage
// behind the waiting candle is occupied.
module cumulative_volume_delta_bars (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cvd_pkg::cvd_in_t   in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cvd_pkg::cvd_out_t  out_data
);
    import cvd_pkg::*;

    // Stage 2 carries the day product and the trade direction.
    typedef struct packed {
        logic [PROD_W-1:0] prod;
        dir_t              dir;
        logic [VOL_W-1:0]  volume;
        logic              bar_end;
    } s2_t;

    // Stage 3 carries the bar summary and the day-change flag.
    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] delta;
        logic signed [ACC_WIDTH-1:0] delta_hi;
        logic signed [ACC_WIDTH-1:0] delta_lo;
        logic                        zero_carry;
        logic                        bar_end;
    } s3_t;

    // Pipeline valid bits and payloads
    logic     s1_valid_reg, s1_valid_next;
    cvd_in_t  s1_reg;
    logic     s2_valid_reg, s2_valid_next;
    s2_t      s2_reg, s2_next;
    logic     s3_valid_reg, s3_valid_next;
    s3_t      s3_reg, s3_next;
    logic     out_valid_reg, out_valid_next;
    cvd_out_t out_reg, out_next;

    // Bar state
    logic signed [ACC_WIDTH-1:0] delta_reg, delta_next;
    logic signed [ACC_WIDTH-1:0] hi_reg, hi_next;
    logic signed [ACC_WIDTH-1:0] lo_reg, lo_next;
    logic [DAY_W-1:0]            prev_day_reg, prev_day_next;
    logic                        seen_reg, seen_next;
    logic                        inside_reg, inside_next;
    logic signed [ACC_WIDTH-1:0] carried_reg, carried_next;

    // Flow control
    logic out_free, s3_go, s3_free, s2_go, s2_free, s1_go, s1_free;

    assign out_free = !out_valid_reg || out_ready;
    assign s3_go    = s3_valid_reg && (!s3_reg.bar_end || out_free);
    assign s3_free  = !s3_valid_reg || s3_go;
    assign s2_go    = s2_valid_reg && s3_free;
    assign s2_free  = !s2_valid_reg || s2_go;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s1_go;
    assign in_ready = s1_free;

    // Stage 1: day product and price direction
    logic [XW-1:0]      day_x;
    logic [RECIP_W-1:0] recip;

    assign day_x = s1_reg.bar_time[TIME_WIDTH-1:DAY_SHIFT];
    assign recip = RECIP[RECIP_W-1:0];

    always_comb
    begin
        s2_next.prod    = PROD_W'(day_x) * PROD_W'(recip);
        s2_next.volume  = s1_reg.volume;
        s2_next.bar_end = s1_reg.bar_end;
        if (!s1_reg.has_trade)
        begin
            s2_next.dir = DIR_NONE;
        end
        else if (s1_reg.close_price > s1_reg.open_price)
        begin
            s2_next.dir = DIR_UP;
        end
        else if (s1_reg.close_price < s1_reg.open_price)
        begin
            s2_next.dir = DIR_DOWN;
        end
        else
        begin
            s2_next.dir = DIR_NONE;
        end
    end

    // Stage 2: running delta with high/low tracking
    logic                        bar_start;
    logic [DAY_W-1:0]            day;
    logic signed [ACC_WIDTH-1:0] base_d, base_hi, base_lo, new_d;
    logic signed [ACC_X-1:0]     vol_x, step_x;

    assign bar_start = !inside_reg;
    assign day       = s2_reg.prod[RECIP_SHIFT +: DAY_W];
    assign base_d    = bar_start ? '0 : delta_reg;
    assign base_hi   = bar_start ? '0 : hi_reg;
    assign base_lo   = bar_start ? '0 : lo_reg;
    assign vol_x     = signed'(ACC_X'(s2_reg.volume));

    always_comb
    begin
        case (s2_reg.dir)
            DIR_UP:   step_x = vol_x;
            DIR_DOWN: step_x = -vol_x;
            default:  step_x = '0;
        endcase
        new_d = sat_acc(ACC_X'(base_d) + step_x);

        s3_next.delta      = new_d;
        s3_next.delta_hi   = (new_d > base_hi) ? new_d : base_hi;
        s3_next.delta_lo   = (new_d < base_lo) ? new_d : base_lo;
        s3_next.zero_carry = bar_start && seen_reg && (day != prev_day_reg);
        s3_next.bar_end    = s2_reg.bar_end;
    end

    always_comb
    begin
        delta_next    = delta_reg;
        hi_next       = hi_reg;
        lo_next       = lo_reg;
        prev_day_next = prev_day_reg;
        seen_next     = seen_reg;
        inside_next   = inside_reg;
        if (s2_go)
        begin
            delta_next  = s3_next.delta;
            hi_next     = s3_next.delta_hi;
            lo_next     = s3_next.delta_lo;
            inside_next = !s2_reg.bar_end;
            if (bar_start)
            begin
                prev_day_next = day;
                seen_next     = 1'b1;
            end
        end
    end

    // Stage 3: candle sums against the carried total
    logic signed [ACC_WIDTH-1:0] start_v, high_v, low_v, close_v;

    assign start_v = s3_reg.zero_carry ? '0 : carried_reg;
    assign high_v  = sat_acc(ACC_X'(start_v) + ACC_X'(s3_reg.delta_hi));
    assign low_v   = sat_acc(ACC_X'(start_v) + ACC_X'(s3_reg.delta_lo));
    assign close_v = sat_acc(ACC_X'(start_v) + ACC_X'(s3_reg.delta));

    always_comb
    begin
        out_next.bar_open  = to_out(start_v);
        out_next.bar_high  = to_out(high_v);
        out_next.bar_low   = to_out(low_v);
        out_next.bar_close = to_out(close_v);

        carried_next = carried_reg;
        if (s3_go)
        begin
            if (s3_reg.bar_end)
            begin
                carried_next = close_v;
            end
            else if (s3_reg.zero_carry)
            begin
                carried_next = '0;
            end
        end
    end

    // Valid bits: load on upstream advance, drop when the item moves on
    always_comb
    begin
        s1_valid_next  = in_valid && in_ready ? 1'b1 : (s1_go ? 1'b0 : s1_valid_reg);
        s2_valid_next  = s1_go ? 1'b1 : (s2_go ? 1'b0 : s2_valid_reg);
        s3_valid_next  = s2_go ? 1'b1 : (s3_go ? 1'b0 : s3_valid_reg);
        out_valid_next = (s3_go && s3_reg.bar_end) ? 1'b1
                       : (out_ready ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            delta_reg     <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            prev_day_reg  <= '0;
            seen_reg      <= 1'b0;
            inside_reg    <= 1'b0;
            carried_reg   <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
            delta_reg     <= delta_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            prev_day_reg  <= prev_day_next;
            seen_reg      <= seen_next;
            inside_reg    <= inside_next;
            carried_reg   <= carried_next;
        end
    end

    // Payload registers: load only when the stage takes a new transaction
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_reg <= in_data;
        end
        if (s1_go)
        begin
            s2_reg <= s2_next;
        end
        if (s2_go)
        begin
            s3_reg <= s3_next;
        end
        if (s3_go && s3_reg.bar_end)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Bar extremes always bracket the running delta and zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        hi_reg >= delta_reg && hi_reg >= 0 && lo_reg <= delta_reg && lo_reg <= 0)
    else $error("bar high/low do not bracket running delta");

    // A candle's open and close lie between its low and high.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && ACC_WIDTH == OUT_W |->
            out_reg.bar_low <= out_reg.bar_open && out_reg.bar_open <= out_reg.bar_high &&
            out_reg.bar_low <= out_reg.bar_close && out_reg.bar_close <= out_reg.bar_high)
    else $error("candle open/close outside low..high");

    // Input backpressure only comes from a stalled candle at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid_reg && !out_ready && s3_valid_reg && s3_reg.bar_end)
    else $error("input stalled without output backpressure");

    // A bar_end item leaving stage 3 always lands in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        s3_go && s3_reg.bar_end |=> out_valid_reg)
    else $error("candle lost between stage 3 and output");

endmodule

// ----- test/cumulative_volume_delta_bars_tb.sv -----
`timescale 1ns / 1ps

module cumulative_volume_delta_bars_tb;
    import cvd_pkg::*;

    localparam int CLK_PERIOD   = 20;
    // Longest stretch with no transaction on either side before giving up.
    // The forced receiver hold and the widest sender gap both sit well below it.
    localparam int STALL_LIMIT  = 3000;
    localparam int LONG_HOLD    = 400;
    // Settle time after the final drain; a stray candle in it is an error.
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_ITEMS = 1250;
    // Full-volume trades in one long one-way bar; a few of these bars push
    // the bar delta and the carried total to large magnitudes of both signs.
    localparam int RUN_LEN      = 40;
    localparam logic [TIME_WIDTH-1:0] TIME_MAX  = '1;
    localparam logic [PRICE_W-1:0]    PRICE_MAX = '1;
    localparam logic [VOL_W-1:0]      VOL_MAX   = '1;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_CADENCE
    } rx_mode_t;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     in_valid  = 1'b0;
    logic     in_ready;
    cvd_in_t  in_data   = '0;
    logic     out_valid;
    logic     out_ready = 1'b0;
    cvd_out_t out_data;

    // Candle predictor state: running day total and the current bar's
    // excursion, all at the accumulator width.
    logic signed [ACC_WIDTH-1:0] running_total = '0;
    logic signed [ACC_WIDTH-1:0] bar_net       = '0;
    logic signed [ACC_WIDTH-1:0] bar_peak      = '0;
    logic signed [ACC_WIDTH-1:0] bar_trough    = '0;
    longint unsigned             last_day      = 0;
    bit                          day_known     = 1'b0;
    bit                          in_bar        = 1'b0;

    cvd_out_t candle_q[$];

    int fail_count      = 0;
    int items_sent      = 0;
    int candles_checked = 0;

    // Sender burst shaping
    int burst_left    = 0;
    bit steady_sender = 1'b0;

    // Receiver stall pattern; a long hold is requested by bumping hold_asked
    int       hold_asked  = 0;
    int       hold_served = 0;
    int       hold_left   = 0;
    int       mode_left   = 0;
    int       phase_count = 0;
    rx_mode_t rx_mode     = RX_FREE;

    int       quiet_cycles = 0;
    cvd_out_t want;

    cumulative_volume_delta_bars u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Candle prediction
    // ------------------------------------------------------------------

    // Add in 64 bits, then clamp to the signed accumulator range.
    function automatic logic signed [ACC_WIDTH-1:0] clamp_sum(
        input logic signed [ACC_WIDTH-1:0] a,
        input longint                      b
    );
        longint s;
        s = longint'(a) + b;
        if (s > longint'(ACC_MAX))
        begin
            return ACC_MAX;
        end
        if (s < longint'(ACC_MIN))
        begin
            return ACC_MIN;
        end
        return s[ACC_WIDTH-1:0];
    endfunction

    // Advance the predictor by one accepted transaction and queue the
    // candle it closes, if any.
    function automatic void predict_candle(input cvd_in_t item);
        longint unsigned             day;
        dir_t                        dir;
        cvd_out_t                    candle;
        logic signed [ACC_WIDTH-1:0] fin;

        // Open a bar: only its first transaction's time decides the day.
        // The first bar after reset has nothing to compare against.
        if (!in_bar)
        begin
            day = 64'(item.bar_time) / 64'(SECS_PER_DAY);
            if (day_known && day != last_day)
            begin
                running_total = '0;
            end
            last_day   = day;
            day_known  = 1'b1;
            in_bar     = 1'b1;
            bar_net    = '0;
            bar_peak   = '0;
            bar_trough = '0;
        end

        if (!item.has_trade)
        begin
            dir = DIR_NONE;
        end
        else if (item.close_price > item.open_price)
        begin
            dir = DIR_UP;
        end
        else if (item.close_price < item.open_price)
        begin
            dir = DIR_DOWN;
        end
        else
        begin
            dir = DIR_NONE;
        end

        case (dir)
            DIR_UP:   bar_net = clamp_sum(bar_net, longint'(item.volume));
            DIR_DOWN: bar_net = clamp_sum(bar_net, -longint'(item.volume));
            default:  ;
        endcase
        if (bar_net > bar_peak)
        begin
            bar_peak = bar_net;
        end
        if (bar_net < bar_trough)
        begin
            bar_trough = bar_net;
        end

        if (item.bar_end)
        begin
            fin              = clamp_sum(running_total, longint'(bar_net));
            candle.bar_open  = OUT_W'(running_total);
            candle.bar_high  = OUT_W'(clamp_sum(running_total, longint'(bar_peak)));
            candle.bar_low   = OUT_W'(clamp_sum(running_total, longint'(bar_trough)));
            candle.bar_close = OUT_W'(fin);
            candle_q.push_back(candle);
            running_total = fin;
            in_bar        = 1'b0;
        end
    endfunction

    // ------------------------------------------------------------------
    // Transaction helpers
    // ------------------------------------------------------------------

    function automatic cvd_in_t make_item(
        input logic [TIME_WIDTH-1:0] t,
        input logic [PRICE_W-1:0]    open_p,
        input logic [PRICE_W-1:0]    close_p,
        input logic [VOL_W-1:0]      vol,
        input bit                    trade,
        input bit                    last
    );
        cvd_in_t item;
        item.bar_time    = t;
        item.open_price  = open_p;
        item.close_price = close_p;
        item.volume      = vol;
        item.has_trade   = trade;
        item.bar_end     = last;
        return item;
    endfunction

    function automatic logic [TIME_WIDTH-1:0] random_time();
        return TIME_WIDTH'({$urandom, $urandom});
    endfunction

    // Random sub-bar: ties, price extremes and volume extremes show up often.
    function automatic cvd_in_t random_trade();
        cvd_in_t item;
        item.bar_time   = random_time();
        item.open_price = ($urandom_range(0, 7) == 0) ? PRICE_MAX : $urandom;
        case ($urandom_range(0, 5))
            0:       item.close_price = item.open_price;
            1:       item.close_price = '0;
            2:       item.close_price = PRICE_MAX;
            default: item.close_price = $urandom;
        endcase
        case ($urandom_range(0, 4))
            0:       item.volume = VOL_MAX;
            1:       item.volume = $urandom_range(0, 255);
            default: item.volume = $urandom;
        endcase
        item.has_trade = ($urandom_range(0, 9) != 0);
        item.bar_end   = 1'b0;
        return item;
    endfunction

    // Offer one transaction and hold it until accepted. The sender works in
    // bursts; between bursts it drops valid for a random gap. Valid is only
    // lowered on a step where it is not also raised.
    task automatic send_item(input cvd_in_t item);
        @(negedge clk);
        if (!steady_sender && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 48);
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        predict_candle(item);
        items_sent++;
    endtask

    // Drop valid and wait for every queued candle to come out.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (candle_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // One bar of 'count' full-volume trades all in one direction.
    task automatic send_run(input logic [TIME_WIDTH-1:0] t, input dir_t dir, input int count);
        cvd_in_t item;
        for (int i = 0; i < count; i++)
        begin
            item.open_price  = $urandom_range(1000, 32'h7fff_ffff);
            item.close_price = (dir == DIR_UP) ? item.open_price + $urandom_range(1, 1000)
                                               : item.open_price - $urandom_range(1, 1000);
            item.bar_time    = (i == 0) ? t : random_time();
            item.volume      = VOL_MAX;
            item.has_trade   = 1'b1;
            item.bar_end     = (i == count - 1);
            send_item(item);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Hand-built bars covering field extremes, every trade direction,
    // empty bars, day carry and day reset.
    task automatic test_directed_cases();
        // First bar after reset is empty: flat candle at zero.
        send_item(make_item(TIME_WIDTH'(20000), '0, '0, VOL_MAX, 1'b0, 1'b1));
        // Mixed bar on day 0. Later transactions carry a far-off time that
        // must be ignored.
        send_item(make_item(TIME_WIDTH'(3600), '0, PRICE_MAX, VOL_MAX, 1'b1, 1'b0));
        send_item(make_item(TIME_MAX, PRICE_MAX, '0, 32'd5, 1'b1, 1'b0));
        send_item(make_item(TIME_MAX, PRICE_MAX, PRICE_MAX, VOL_MAX, 1'b1, 1'b0));
        send_item(make_item('0, '0, PRICE_MAX, VOL_MAX, 1'b0, 1'b0));
        send_item(make_item(TIME_MAX, 32'd10, 32'd11, '0, 1'b1, 1'b1));
        // Same day: total carries over, goes below the open.
        send_item(make_item(TIME_WIDTH'(7200), 32'd500, 32'd499, VOL_MAX, 1'b1, 1'b0));
        send_item(make_item(TIME_MAX, 32'd1, 32'd2, 32'd1, 1'b1, 1'b1));
        // Empty bar mid-day: flat at the carried total.
        send_item(make_item(TIME_WIDTH'(86399), PRICE_MAX, '0, VOL_MAX, 1'b0, 1'b1));
        // New day: carried total clears.
        send_item(make_item(TIME_WIDTH'(86400), 32'd3, 32'd9, 32'd100, 1'b1, 1'b1));
        // Last second of the same day keeps the total.
        send_item(make_item(TIME_WIDTH'(2 * 86400 - 1), 32'd3, 32'd9, 32'd7, 1'b1, 1'b1));
        // Largest time, then back to day 0.
        send_item(make_item(TIME_MAX, '0, PRICE_MAX, VOL_MAX, 1'b1, 1'b1));
        send_item(make_item('0, 32'd9, 32'd8, 32'd9, 1'b1, 1'b1));
        // Equal prices at zero move nothing.
        send_item(make_item('0, '0, '0, VOL_MAX, 1'b1, 1'b1));
        // Dip then rise then fall within one bar: high and low both off start.
        send_item(make_item('0, 32'd20, 32'd10, 32'd50, 1'b1, 1'b0));
        send_item(make_item(TIME_MAX, 32'd10, 32'd20, 32'd80, 1'b1, 1'b0));
        send_item(make_item(TIME_MAX, 32'd20, 32'd10, 32'd100, 1'b1, 1'b1));
        wait_for_drain();
    endtask

    // Hold the receiver off while the sender streams closing transactions,
    // so the pipeline fills and input ready drops.
    task automatic test_backpressure();
        cvd_in_t item;
        hold_asked++;
        steady_sender = 1'b1;
        for (int i = 0; i < 32; i++)
        begin
            item         = random_trade();
            item.bar_end = 1'b1;
            send_item(item);
        end
        steady_sender = 1'b0;
        wait_for_drain();
    endtask

    // Mostly well-formed bars with random content and time steps, some
    // stray transactions that break bars apart, and occasional pauses.
    task automatic test_random_bars();
        int                    target;
        int                    len;
        logic [TIME_WIDTH-1:0] bar_start;
        cvd_in_t               item;

        target    = items_sent + RANDOM_ITEMS;
        bar_start = random_time();
        while (items_sent < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                item         = random_trade();
                item.bar_end = 1'($urandom_range(0, 1));
                send_item(item);
            end
            else
            begin
                case ($urandom_range(0, 6))
                    0:       ;
                    1, 2, 3: bar_start = bar_start + $urandom_range(60, 3600);
                    4:       bar_start = bar_start + 86400 * $urandom_range(1, 3);
                    5:       bar_start = bar_start - $urandom_range(1, 200000);
                    default: bar_start = random_time();
                endcase
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    item = random_trade();
                    if (i == 0)
                    begin
                        item.bar_time = bar_start;
                    end
                    item.bar_end = (i == len - 1);
                    send_item(item);
                end
            end
            if ($urandom_range(0, 199) == 0)
            begin
                wait_for_drain();
            end
        end
        wait_for_drain();
    endtask

    // Long one-way bars at full volume on one day: the bar delta and the
    // carried total swing to large positive and negative values.
    task automatic test_long_runs();
        logic [TIME_WIDTH-1:0] t;
        t = TIME_WIDTH'(5 * 86400 + 100);
        steady_sender = 1'b1;
        send_run(t, DIR_UP, RUN_LEN);     // large positive bar delta
        send_run(t, DIR_UP, 4);           // carried total keeps growing
        send_run(t, DIR_DOWN, RUN_LEN);   // large negative bar delta, close near zero
        send_run(t, DIR_DOWN, RUN_LEN);   // carried total goes well negative
        send_run(t, DIR_DOWN, 3);
        send_run(t, DIR_UP, 3);
        steady_sender = 1'b0;
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------
    // Receiver: own stall pattern, changing modes, plus a forced long hold
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left   = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            else
            begin
                mode_left--;
            end
            phase_count++;
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_FREE:  out_ready <= 1'b1;
                    RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
                    RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
                    default:  out_ready <= ((phase_count % 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare every accepted candle against the oldest prediction
    // ------------------------------------------------------------------
    task automatic check_field(
        input string                   field,
        input logic signed [OUT_W-1:0] exp_val,
        input logic signed [OUT_W-1:0] act_val
    );
        if (act_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, exp_val, act_val);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (candle_q.size() == 0)
            begin
                $error("candle with no prediction pending: open %0d close %0d",
                       out_data.bar_open, out_data.bar_close);
                fail_count++;
            end
            else
            begin
                want = candle_q.pop_front();
                check_field("bar_open", want.bar_open, out_data.bar_open);
                check_field("bar_high", want.bar_high, out_data.bar_high);
                check_field("bar_low", want.bar_low, out_data.bar_low);
                check_field("bar_close", want.bar_close, out_data.bar_close);
                candles_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: abort when neither side moves a transaction for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        // Hold reset, then release it on a falling edge.
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_backpressure();
        test_random_bars();
        test_long_runs();

        // Let the pipeline settle; any stray candle now is an error.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("summary: %0d transactions sent, %0d candles checked", items_sent,
                 candles_checked);
        $display("summary: directed extremes, long output hold, random bars, full-volume runs");
        if (fail_count == 0 && candle_q.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/cvd_pkg.sv
sv/cumulative_volume_delta_bars.sv
test/cumulative_volume_delta_bars_tb.sv
